[rtl/zxscr_pkg.sv]
// Shared types and constants for the screen cell renderer.
`timescale 1ns / 1ps

package zxscr_pkg;

    localparam int STORE_DEPTH = 6912;
    localparam int STORE_AW    = 13;
    localparam int BYTE_W      = 8;
    localparam int CELL_PIXELS = 8;
    localparam int COLOR_W     = 4;

    localparam logic [STORE_AW-1:0] ATTR_BASE        = 13'd6144;
    localparam logic [7:0]          LAST_ROW         = 8'd191;
    localparam logic [4:0]          LAST_COL         = 5'd31;
    localparam logic [7:0]          FLASH_PERIOD_RST = 8'd12;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_RENDER = 2'd2
    } cmd_t;

endpackage

[rtl/zxscr_ram.sv]
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps

module zxscr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 6912
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/zxscr_fmt.sv]
// Expands a pixel byte and its attribute byte into eight colour indices.
`timescale 1ns / 1ps

module zxscr_fmt (
    input  logic [zxscr_pkg::BYTE_W-1:0]                       pix_byte,
    input  logic [zxscr_pkg::BYTE_W-1:0]                       attr_byte,
    input  logic                                               flash_mask,
    output logic [zxscr_pkg::CELL_PIXELS*zxscr_pkg::COLOR_W-1:0] pixels
);

    import zxscr_pkg::*;

    logic [BYTE_W-1:0]  bits;
    logic [COLOR_W-1:0] ink;
    logic [COLOR_W-1:0] paper;

    assign bits  = pix_byte ^ {BYTE_W{attr_byte[7] & flash_mask}};
    assign ink   = {attr_byte[6], attr_byte[2:0]};
    assign paper = {attr_byte[6], attr_byte[5:3]};

    always_comb begin
        for (int i = 0; i < CELL_PIXELS; i++) begin
            pixels[i*COLOR_W +: COLOR_W] = bits[CELL_PIXELS-1-i] ? ink : paper;
        end
    end

endmodule

[rtl/zx_screen_cell_renderer_unit.sv]
// Top level of the screen cell renderer: control, raster walk, flash timing and output register.
//
//   Channel  Direction  Carries
//   s_axis   in         tuser = command; tdata = address, data
//   m_axis   out        tdata = pixel_0..pixel_7; tuser = refresh_frame; tlast = last_cell
//   cfg      in         flash_period write
//
// A write, a frame tick or an unused command gives its item from the output register in the cycle after it is taken.
// A render steps through ST_ATTR and ST_DONE: the single RAM port reads the pixel byte, then the attribute.
// Reset is synchronous; no clearing pass runs, the screen store holds no reset value.
// A full output register that is not taken stops input acceptance.
`timescale 1ns / 1ps

module zx_screen_cell_renderer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // address [12:0], data [20:13], zero [23:21]
    input  logic [1:0]  s_axis_tuser,   // command [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // pixel_0 [3:0] up to pixel_7 [31:28]
    output logic        m_axis_tuser,   // refresh_frame [0]
    output logic        m_axis_tlast,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    import zxscr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ATTR,
        ST_DONE
    } state_t;

    state_t                        state_reg;
    logic [7:0]                    flash_period_reg;
    logic [7:0]                    flash_cnt_reg;
    logic [7:0]                    flash_cnt_next;
    logic [7:0]                    flash_cnt_inc;
    logic                          flash_mask_reg;
    logic                          flash_mask_next;
    logic [7:0]                    scan_row_reg;
    logic [7:0]                    scan_row_next;
    logic [4:0]                    scan_col_reg;
    logic [4:0]                    scan_col_next;
    logic                          cell_last;
    logic [STORE_AW-1:0]           attr_addr_reg;
    logic [STORE_AW-1:0]           pix_addr;
    logic                          last_pend_reg;
    logic [BYTE_W-1:0]             pix_byte_reg;
    logic                          m_valid_reg;
    logic [31:0]                   m_pix_reg;
    logic                          m_refresh_reg;
    logic                          m_last_reg;
    logic [31:0]                   fmt_pixels;

    cmd_t                          cmd;
    logic [STORE_AW-1:0]           in_addr;
    logic [BYTE_W-1:0]             in_data;
    logic                          out_free;
    logic                          s_fire;
    logic                          ram_we;
    logic                          ram_re;
    logic [STORE_AW-1:0]           ram_addr;
    logic [BYTE_W-1:0]             ram_rdata;

    assign cmd     = cmd_t'(s_axis_tuser);
    assign in_addr = s_axis_tdata[STORE_AW-1:0];
    assign in_data = s_axis_tdata[STORE_AW +: BYTE_W];

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_pix_reg;
    assign m_axis_tuser  = m_refresh_reg;
    assign m_axis_tlast  = m_last_reg;

    // Interleaved bitmap layout: third, pixel line, character row, column.
    assign pix_addr = {scan_row_reg[7:6], scan_row_reg[2:0], scan_row_reg[5:3], scan_col_reg};

    assign flash_cnt_inc = flash_cnt_reg + 8'd1;

    always_comb begin
        flash_cnt_next  = flash_cnt_inc;
        flash_mask_next = flash_mask_reg;
        if (flash_cnt_inc >= flash_period_reg) begin
            flash_cnt_next  = 8'd0;
            flash_mask_next = !flash_mask_reg;
        end
    end

    always_comb begin
        cell_last     = (scan_row_reg == LAST_ROW) && (scan_col_reg == LAST_COL);
        scan_col_next = scan_col_reg + 5'd1;
        scan_row_next = scan_row_reg;
        if (scan_col_reg == LAST_COL) begin
            scan_row_next = (scan_row_reg == LAST_ROW) ? 8'd0 : scan_row_reg + 8'd1;
        end
    end

    always_comb begin
        ram_we   = s_fire && (cmd == CMD_WRITE) && (in_addr < STORE_AW'(STORE_DEPTH));
        ram_re   = (s_fire && (cmd == CMD_RENDER)) || (state_reg == ST_ATTR);
        ram_addr = pix_addr;
        if (state_reg == ST_ATTR) begin
            ram_addr = attr_addr_reg;
        end else if (cmd == CMD_WRITE) begin
            ram_addr = in_addr;
        end
    end

    zxscr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (in_data),
        .rdata (ram_rdata)
    );

    zxscr_fmt u_fmt (
        .pix_byte   (pix_byte_reg),
        .attr_byte  (ram_rdata),
        .flash_mask (flash_mask_reg),
        .pixels     (fmt_pixels)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            flash_period_reg <= FLASH_PERIOD_RST;
            flash_cnt_reg    <= 8'd0;
            flash_mask_reg   <= 1'b0;
            scan_row_reg     <= 8'd0;
            scan_col_reg     <= 5'd0;
        end else begin
            if (cfg_wr_en) begin
                flash_period_reg <= cfg_wr_data;
            end
            if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        m_pix_reg     <= '0;
                        m_refresh_reg <= 1'b0;
                        m_last_reg    <= 1'b0;
                        case (cmd)
                            CMD_TICK: begin
                                m_valid_reg    <= 1'b1;
                                flash_cnt_reg  <= flash_cnt_next;
                                flash_mask_reg <= flash_mask_next;
                                m_refresh_reg  <= !flash_cnt_next[0];
                            end
                            CMD_RENDER: begin
                                attr_addr_reg <= ATTR_BASE
                                                 + {3'd0, scan_row_reg[7:3], scan_col_reg};
                                last_pend_reg <= cell_last;
                                scan_row_reg  <= scan_row_next;
                                scan_col_reg  <= scan_col_next;
                                state_reg     <= ST_ATTR;
                            end
                            default: begin
                                m_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_ATTR: begin
                    pix_byte_reg <= ram_rdata;
                    state_reg    <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_pix_reg     <= fmt_pixels;
                        m_refresh_reg <= 1'b0;
                        m_last_reg    <= last_pend_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_render_enters_attr: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (cmd == CMD_RENDER) |=> state_reg == ST_ATTR)
        else $error("Render item did not start the attribute read.");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_row_reg <= LAST_ROW)
        else $error("Raster row left the visible area.");

    a_col_moves_on_render: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(scan_col_reg)
        |-> $past(s_fire) && ($past(cmd) == CMD_RENDER))
        else $error("Raster column moved without a render item.");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_refresh_reg && m_last_reg))
        else $error("Refresh flag and last cell flag are set on one item.");

    a_no_write_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE) && !ram_re)
        else $error("Store write collided with a render read.");
`endif

endmodule
